// ----- design/qrpl_pkg.sv -----
// ----------------------------------------------------------------------------
// Quadratic ring power ladder package
// Shared constants, the datapath command code and the status struct.
// ----------------------------------------------------------------------------
package qrpl_pkg;

  localparam int unsigned DEF_WIDTH = 64;
  localparam int unsigned FIELD_W   = 64;

  // Datapath operation codes.
  localparam logic [3:0] OP_LOAD   = 4'd0;  // latch inputs, start reductions
  localparam logic [3:0] OP_SQ_A   = 4'd1;  // m = s * a
  localparam logic [3:0] OP_SQ_B   = 4'd2;  // s2 = (m + 2t) * s
  localparam logic [3:0] OP_SQ_C   = 4'd3;  // t2 = (t + s) * (t - s)
  localparam logic [3:0] OP_MX_A   = 4'd4;  // m = a * s
  localparam logic [3:0] OP_MX_B   = 4'd5;  // m2 = m + T * s
  localparam logic [3:0] OP_MX_C   = 4'd6;  // p = t * T
  localparam logic [3:0] OP_NONE   = 4'd7;

  typedef struct packed {
    logic       start;
    logic [3:0] op;
  } qrpl_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       bad;
    logic       bit_val;
  } qrpl_stat_t;

endpackage

// ----- design/qrpl_if.sv -----
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries valid, ready and a packed payload between a source and a sink.
// ----------------------------------------------------------------------------
interface qrpl_if #(
  parameter int unsigned PW = 1
);
  logic          valid;
  logic          ready;
  logic [PW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/qrpl_datapath.sv -----
// ----------------------------------------------------------------------------
// Ladder datapath
// Holds n, a, T and the ladder element, and runs one shared serial modular
// unit that does reductions and multiplications one bit per cycle.
// ----------------------------------------------------------------------------
module qrpl_datapath #(
  parameter int unsigned WIDTH = qrpl_pkg::DEF_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  qrpl_pkg::qrpl_cmd_t   cmd,
  input  logic [6:0]            bit_idx,
  input  logic [WIDTH-1:0]      in_n,
  input  logic [WIDTH-1:0]      in_a,
  input  logic [WIDTH-1:0]      in_t,
  output qrpl_pkg::qrpl_stat_t  stat,
  output logic [WIDTH-1:0]      res_s,
  output logic [WIDTH-1:0]      res_t
);
  import qrpl_pkg::*;

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] n, a, tt, s, t, mtmp, mtmp2;
  logic [WIDTH-1:0] acc, mx, my;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [3:0]       op;
  logic [1:0]       red_phase;  // 0: reduce a, 1: reduce T, 2: done

  function automatic logic [WIDTH-1:0] addm(input logic [WIDTH-1:0] x,
                                            input logic [WIDTH-1:0] y,
                                            input logic [WIDTH-1:0] m);
    logic [WIDTH:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    if (sum >= {1'b0, m}) begin
      addm = WIDTH'(sum - {1'b0, m});
    end else begin
      addm = sum[WIDTH-1:0];
    end
  endfunction

  function automatic logic [WIDTH-1:0] subm(input logic [WIDTH-1:0] x,
                                            input logic [WIDTH-1:0] y,
                                            input logic [WIDTH-1:0] m);
    if (x >= y) begin
      subm = x - y;
    end else begin
      subm = m - (y - x);
    end
  endfunction

  // Reduction of a raw value mod n is done as x * 1 with x fed bit-serially
  // into the doubling accumulator, which tolerates x >= n.
  logic [WIDTH:0]   dbl;
  logic [WIDTH+1:0] dsum;
  logic [WIDTH-1:0] acc_next;
  logic [WIDTH-1:0] addend;
  logic             ybit;
  logic             n_ok;

  assign ybit = my[WIDTH-1];
  assign addend = ybit ? mx : '0;
  always_comb begin
    dbl = {acc, 1'b0};
    if (dbl >= {1'b0, n}) begin
      dbl = dbl - {1'b0, n};
    end
    dsum = {1'b0, dbl} + {2'b0, addend};
    if (dsum >= {2'b0, n}) begin
      dsum = dsum - {2'b0, n};
    end
    acc_next = dsum[WIDTH-1:0];
  end

  assign n_ok = n[0] && (n >= WIDTH'(3));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      red_phase <= 2'd2;
    end else if (cmd.start) begin
      busy <= 1'b1;
      op <= cmd.op;
      cnt <= '0;
      acc <= '0;
      unique case (cmd.op)
        OP_LOAD: begin
          n <= in_n;
          a <= in_a;
          tt <= in_t;
          red_phase <= 2'd0;
          mx <= WIDTH'(1);
          my <= in_a;
        end
        OP_SQ_A: begin mx <= s; my <= a; end
        OP_SQ_B: begin mx <= addm(mtmp, addm(t, t, n), n); my <= s; end
        OP_SQ_C: begin mx <= addm(t, s, n); my <= subm(t, s, n); end
        OP_MX_A: begin mx <= a; my <= s; end
        OP_MX_B: begin mx <= tt; my <= s; end
        OP_MX_C: begin mx <= t; my <= tt; end
        default: busy <= 1'b0;
      endcase
    end else if (busy) begin
      // In the load phase a reduction of a raw value uses x = 1, y = raw;
      // feeding the raw bits through the doubling path yields raw mod n.
      if (op == OP_LOAD && red_phase == 2'd0 && cnt == '0 && !n_ok) begin
        busy <= 1'b0;
        red_phase <= 2'd2;
        s <= '1;
        t <= '1;
      end else if (cnt == CW'(WIDTH)) begin
        unique case (op)
          OP_LOAD: begin
            if (red_phase == 2'd0) begin
              a <= acc;
              red_phase <= 2'd1;
              cnt <= '0;
              acc <= '0;
              my <= tt;
            end else begin
              tt <= acc;
              s <= WIDTH'(1);
              t <= acc;
              red_phase <= 2'd2;
              busy <= 1'b0;
            end
          end
          OP_SQ_A: begin mtmp <= acc; busy <= 1'b0; end
          OP_SQ_B: begin mtmp2 <= acc; busy <= 1'b0; end
          OP_SQ_C: begin s <= mtmp2; t <= acc; busy <= 1'b0; end
          OP_MX_A: begin mtmp <= acc; busy <= 1'b0; end
          OP_MX_B: begin mtmp2 <= addm(mtmp, acc, n); busy <= 1'b0; end
          OP_MX_C: begin
            s <= addm(mtmp2, t, n);
            t <= subm(acc, s, n);
            busy <= 1'b0;
          end
          default: busy <= 1'b0;
        endcase
      end else begin
        acc <= acc_next;
        my <= {my[WIDTH-2:0], 1'b0};
        cnt <= cnt + CW'(1);
      end
    end
  end

  assign stat.busy = busy | cmd.start;
  assign stat.bad = !n_ok;
  assign stat.bit_val = n[bit_idx[$clog2(WIDTH)-1:0]];
  assign res_s = s;
  assign res_t = t;

  a_red_done: assert property (@(posedge clk) disable iff (rst)
    (busy && op == OP_LOAD && red_phase == 2'd1) |=> (red_phase != 2'd0))
    else $error("reduction phase went back");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt <= CW'(WIDTH)))
    else $error("bit counter overran");
  a_acc_red: assert property (@(posedge clk) disable iff (rst)
    (busy && !cmd.start && cnt != '0) |-> (acc < n))
    else $error("accumulator not reduced");
endmodule

// ----- design/qrpl_ctrl.sv -----
// ----------------------------------------------------------------------------
// Ladder controller
// Walks the bits of n from the top and sequences the datapath operations.
// ----------------------------------------------------------------------------
module qrpl_ctrl #(
  parameter int unsigned WIDTH = qrpl_pkg::DEF_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [WIDTH-1:0]      in_n,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_bad,
  output qrpl_pkg::qrpl_cmd_t   cmd,
  output logic [6:0]            bit_idx,
  input  qrpl_pkg::qrpl_stat_t  stat
);
  import qrpl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [3:0] op;
  logic       issued;
  logic [6:0] top;

  always_comb begin
    top = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (in_n[i]) begin
        top = 7'(i);
      end
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  // The load command starts at the input transfer so the datapath latches the
  // operands while they are still on the channel.
  always_comb begin
    cmd.start = 1'b0;
    cmd.op = op;
    if (state == S_IDLE) begin
      cmd.op = OP_LOAD;
      cmd.start = in_valid;
    end else if (state == S_RUN && !issued) begin
      cmd.start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      issued <= 1'b0;
      op <= OP_NONE;
      bit_idx <= '0;
      out_bad <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            bit_idx <= top;
            op <= OP_LOAD;
            issued <= 1'b1;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (!stat.busy) begin
            issued <= 1'b0;
            unique case (op)
              OP_LOAD: begin
                if (stat.bad) begin
                  out_bad <= 1'b1;
                  state <= S_DONE;
                end else begin
                  out_bad <= 1'b0;
                  state <= S_STEP;
                end
              end
              OP_SQ_A: op <= OP_SQ_B;
              OP_SQ_B: op <= OP_SQ_C;
              OP_SQ_C: begin
                if (stat.bit_val) begin
                  op <= OP_MX_A;
                end else begin
                  state <= S_STEP;
                end
              end
              OP_MX_A: op <= OP_MX_B;
              OP_MX_B: op <= OP_MX_C;
              default: state <= S_STEP;
            endcase
          end
        end
        S_STEP: begin
          if (bit_idx == '0) begin
            state <= S_DONE;
          end else begin
            bit_idx <= bit_idx - 7'd1;
            op <= OP_SQ_A;
            state <= S_RUN;
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
            bit_idx <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_ready) |=> (state == S_DONE))
    else $error("result dropped before transfer");
  a_idle_dp: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cmd.start == in_valid))
    else $error("load command out of step with input transfer");
  a_one_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !cmd.start)
    else $error("double command start");
endmodule

// ----- design/quadratic_ring_power_ladder_top.sv -----
// ----------------------------------------------------------------------------
// Quadratic ring power ladder
// Computes (x+T)^n in Z_n[x]/(x^2 - a x + 1) with a left-to-right ladder.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// in_ch    sink       modulus, ring_coeff_a, shift_t
// out_ch   source     coef_x, coef_one, bad_modulus
//
// One item at a time. Loading reduces a and then T mod n, then each lower bit
// of n costs one step state and 3 serial modular multiplications, plus 3
// more for a one bit. The shared bit-serial modular multiplier sets the run
// time. Reset is synchronous; the result waits in place until the transfer
// on out_ch.
// ----------------------------------------------------------------------------
module quadratic_ring_power_ladder_top #(
  parameter int unsigned WIDTH = qrpl_pkg::DEF_WIDTH
) (
  input logic clk,
  input logic rst,
  qrpl_if.sink   in_ch,
  qrpl_if.source out_ch
);
  import qrpl_pkg::*;

  qrpl_cmd_t        cmd;
  qrpl_stat_t       stat;
  logic [6:0]       bit_idx;
  logic [WIDTH-1:0] res_s, res_t;
  logic             bad;
  logic [WIDTH-1:0] in_n, in_a, in_t;

  assign in_n = in_ch.data[2*FIELD_W +: WIDTH];
  assign in_a = in_ch.data[FIELD_W +: WIDTH];
  assign in_t = in_ch.data[0 +: WIDTH];

  qrpl_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_n(in_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_bad(bad),
    .cmd(cmd), .bit_idx(bit_idx), .stat(stat)
  );

  qrpl_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .bit_idx(bit_idx),
    .in_n(in_n), .in_a(in_a), .in_t(in_t),
    .stat(stat), .res_s(res_s), .res_t(res_t)
  );

  assign out_ch.data = {FIELD_W'(res_s), FIELD_W'(res_t), bad};
endmodule
